// File: sv/rcc_pkg.sv
`timescale 1ns / 1ps
// shared types, field widths and codes of the residue contact counter
package rcc_pkg;

    localparam int COORD_W   = 25;
    localparam int RESNUM_W  = 15;
    localparam int QIDX_W    = 10;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int CUTOFF_W  = 40;
    localparam int MINSEP_W  = 4;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 24;

    localparam int SQ_W  = 2 * COORD_W;
    localparam int SUM_W = SQ_W + 2;

    // neighbors this close but under the minimum separation are counted only across a residue number gap
    localparam int ADJ_SEP_MAX = 3;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUERY_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_STORE_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SEP = 1'd1;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 40'd64000000;
    localparam logic [MINSEP_W-1:0] MINSEP_RESET = 4'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // coordinate index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        logic [2:0][COORD_W-1:0] ca;
        logic [2:0][COORD_W-1:0] cb;
        logic [RESNUM_W-1:0]     resnum;
    } entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic latch_q;
        logic issue;
        logic clear_counts;
    } dp_cmd_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] ca_count;
        logic [COUNT_W-1:0] cb_count;
    } dp_status_t;

endpackage

// File: sv/rcc_datapath.sv
`timescale 1ns / 1ps
// residue store, config registers, pair distance pipeline and contact counters
module rcc_datapath #(
    parameter int MAX_RESIDUES = 1024,
    parameter int IDX_W        = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rcc_pkg::dp_cmd_t                cmd,
    input  logic [IDX_W-1:0]                wr_addr,
    input  rcc_pkg::entry_t                 wr_entry,
    input  logic [IDX_W-1:0]                rd_addr,
    input  logic [IDX_W-1:0]                q_idx,
    input  logic                            cfg_wr_en,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcc_pkg::CUTOFF_W-1:0]    cfg_wdata,
    output rcc_pkg::dp_status_t             status
);
    import rcc_pkg::*;

    localparam int SEP_W = (IDX_W > MINSEP_W) ? IDX_W : MINSEP_W;

    function automatic logic [COORD_W-1:0] coord_abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] n;
        begin
            d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
            n = -d;
            return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
        end
    endfunction

    function automatic logic [RESNUM_W-1:0] resnum_abs_diff(
        input logic [RESNUM_W-1:0] a,
        input logic [RESNUM_W-1:0] b
    );
        logic signed [RESNUM_W:0] d;
        logic        [RESNUM_W:0] n;
        begin
            d = $signed({a[RESNUM_W-1], a}) - $signed({b[RESNUM_W-1], b});
            n = -d;
            return d[RESNUM_W] ? n[RESNUM_W-1:0] : d[RESNUM_W-1:0];
        end
    endfunction

    entry_t mem [MAX_RESIDUES];

    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [MINSEP_W-1:0] min_sep_reg;

    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_j_reg;
    logic             v_rd_reg;
    entry_t           q_entry_reg;

    logic [COORD_W-1:0] ab_ca_reg [3];
    logic [COORD_W-1:0] ab_cb_reg [3];
    logic               ok_ab_reg;
    logic               v_ab_reg;

    logic [SQ_W-1:0] sq_ca_reg [3];
    logic [SQ_W-1:0] sq_cb_reg [3];
    logic            ok_sq_reg;
    logic            v_sq_reg;

    logic [SQ_W:0]   sum_ca_reg;
    logic [SQ_W:0]   sum_cb_reg;
    logic [SQ_W-1:0] z_ca_reg;
    logic [SQ_W-1:0] z_cb_reg;
    logic            ok_sum_reg;
    logic            v_sum_reg;

    logic hit_ca_reg;
    logic hit_cb_reg;
    logic v_hit_reg;

    logic [COUNT_W-1:0] ca_count_reg;
    logic [COUNT_W-1:0] cb_count_reg;

    logic [IDX_W-1:0]    sep;
    logic [SEP_W-1:0]    sep_ext;
    logic [SEP_W-1:0]    min_sep_ext;
    logic [RESNUM_W-1:0] resnum_gap;
    logic                pair_ok;
    logic [SUM_W-1:0]    dist_ca;
    logic [SUM_W-1:0]    dist_cb;

    always_comb begin
        sep         = (rd_j_reg > q_idx) ? (rd_j_reg - q_idx) : (q_idx - rd_j_reg);
        sep_ext     = SEP_W'(sep);
        min_sep_ext = SEP_W'(min_sep_reg);
        resnum_gap  = resnum_abs_diff(q_entry_reg.resnum, rd_data_reg.resnum);
        pair_ok     = (sep != '0) &&
                      ((sep_ext >= min_sep_ext) ||
                       ((sep_ext <= SEP_W'(ADJ_SEP_MAX)) &&
                        (resnum_gap >= RESNUM_W'(min_sep_reg))));
        dist_ca     = SUM_W'(sum_ca_reg) + SUM_W'(z_ca_reg);
        dist_cb     = SUM_W'(sum_cb_reg) + SUM_W'(z_cb_reg);
    end

    // store
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        rd_j_reg <= rd_addr;
        if (cmd.latch_q) begin
            q_entry_reg <= rd_data_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            ab_ca_reg[k] <= coord_abs_diff(q_entry_reg.ca[k], rd_data_reg.ca[k]);
            ab_cb_reg[k] <= coord_abs_diff(q_entry_reg.cb[k], rd_data_reg.cb[k]);
            sq_ca_reg[k] <= SQ_W'(ab_ca_reg[k]) * SQ_W'(ab_ca_reg[k]);
            sq_cb_reg[k] <= SQ_W'(ab_cb_reg[k]) * SQ_W'(ab_cb_reg[k]);
        end
        ok_ab_reg  <= pair_ok;
        ok_sq_reg  <= ok_ab_reg;
        sum_ca_reg <= (SQ_W + 1)'(sq_ca_reg[0]) + (SQ_W + 1)'(sq_ca_reg[1]);
        sum_cb_reg <= (SQ_W + 1)'(sq_cb_reg[0]) + (SQ_W + 1)'(sq_cb_reg[1]);
        z_ca_reg   <= sq_ca_reg[2];
        z_cb_reg   <= sq_cb_reg[2];
        ok_sum_reg <= ok_sq_reg;
        hit_ca_reg <= ok_sum_reg && (dist_ca <= SUM_W'(cutoff_reg));
        hit_cb_reg <= ok_sum_reg && (dist_cb <= SUM_W'(cutoff_reg));
    end

    // control: config, valids, counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= CUTOFF_RESET;
            min_sep_reg  <= MINSEP_RESET;
            v_rd_reg     <= 1'b0;
            v_ab_reg     <= 1'b0;
            v_sq_reg     <= 1'b0;
            v_sum_reg    <= 1'b0;
            v_hit_reg    <= 1'b0;
            ca_count_reg <= '0;
            cb_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CUTOFF:  cutoff_reg  <= cfg_wdata;
                    REG_MIN_SEP: min_sep_reg <= cfg_wdata[MINSEP_W-1:0];
                    default: ;
                endcase
            end
            v_rd_reg  <= cmd.issue;
            v_ab_reg  <= v_rd_reg;
            v_sq_reg  <= v_ab_reg;
            v_sum_reg <= v_sq_reg;
            v_hit_reg <= v_sum_reg;
            if (cmd.clear_counts) begin
                ca_count_reg <= '0;
                cb_count_reg <= '0;
            end else if (v_hit_reg) begin
                if (hit_ca_reg && ca_count_reg != COUNT_MAX) begin
                    ca_count_reg <= ca_count_reg + 1'b1;
                end
                if (hit_cb_reg && cb_count_reg != COUNT_MAX) begin
                    cb_count_reg <= cb_count_reg + 1'b1;
                end
            end
        end
    end

    assign status.busy     = v_rd_reg | v_ab_reg | v_sq_reg | v_sum_reg | v_hit_reg;
    assign status.ca_count = ca_count_reg;
    assign status.cb_count = cb_count_reg;

endmodule

// File: sv/rcc_ctrl.sv
`timescale 1ns / 1ps
// controller: item decode, fill count, sweep sequencing and result register
module rcc_ctrl #(
    parameter int MAX_RESIDUES = 1024,
    parameter int IDX_W        = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rcc_pkg::MODE_W-1:0]     mode,
    input  logic [rcc_pkg::QIDX_W-1:0]     query_index,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rcc_pkg::COUNT_W-1:0]    ca_contacts,
    output logic [rcc_pkg::COUNT_W-1:0]    cb_contacts,
    output logic [rcc_pkg::STATUS_W-1:0]   result_status,
    output rcc_pkg::dp_cmd_t               cmd,
    output logic [IDX_W-1:0]               wr_addr,
    output logic [IDX_W-1:0]               rd_addr,
    output logic [IDX_W-1:0]               q_idx,
    input  rcc_pkg::dp_status_t            dp_status
);
    import rcc_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESIDUES + 1);
    localparam int CMP_W = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READQ,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    loaded_reg, loaded_next;
    logic [IDX_W-1:0]    j_reg, j_next;
    logic [IDX_W-1:0]    q_reg, q_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [COUNT_W-1:0]  m_ca_reg, m_ca_next;
    logic [COUNT_W-1:0]  m_cb_reg, m_cb_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    logic             accept;
    logic             full;
    logic [CMP_W-1:0] q_ext;
    logic             q_miss;
    logic             last_j;

    always_comb begin
        accept = s_tvalid && (state_reg == ST_IDLE);
        full   = (loaded_reg == CNT_W'(MAX_RESIDUES));
        q_ext  = CMP_W'(query_index);
        q_miss = (q_ext >= CMP_W'(loaded_reg));
        last_j = (CNT_W'(j_reg) == (loaded_reg - 1'b1));

        cmd.wr_en        = accept && (mode == MODE_LOAD) && !full;
        cmd.rd_en        = (state_reg == ST_READQ) || (state_reg == ST_SWEEP);
        cmd.issue        = (state_reg == ST_SWEEP);
        cmd.latch_q      = (state_reg == ST_SWEEP) && (j_reg == '0);
        cmd.clear_counts = accept;

        wr_addr = loaded_reg[IDX_W-1:0];
        rd_addr = (state_reg == ST_READQ) ? q_reg : j_reg;

        state_next    = state_reg;
        loaded_next   = loaded_reg;
        j_next        = j_reg;
        q_next        = q_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_ca_next     = m_ca_reg;
        m_cb_next     = m_cb_reg;
        m_status_next = m_status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next = STATUS_OK;
                    state_next  = ST_RESULT;
                    case (mode)
                        MODE_LOAD: begin
                            if (full) begin
                                status_next = STATUS_STORE_FULL;
                            end else begin
                                loaded_next = loaded_reg + 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            if (q_miss) begin
                                status_next = STATUS_QUERY_MISS;
                            end else begin
                                q_next     = q_ext[IDX_W-1:0];
                                state_next = ST_READQ;
                            end
                        end
                        MODE_CLEAR: begin
                            loaded_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READQ: begin
                j_next     = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (last_j) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!dp_status.busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_ca_next     = dp_status.ca_count;
                    m_cb_next     = dp_status.cb_count;
                    m_status_next = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            loaded_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            m_valid_reg <= m_valid_next;
        end
        j_reg        <= j_next;
        q_reg        <= q_next;
        status_reg   <= status_next;
        m_ca_reg     <= m_ca_next;
        m_cb_reg     <= m_cb_next;
        m_status_reg <= m_status_next;
    end

    assign s_tready      = (state_reg == ST_IDLE);
    assign m_tvalid      = m_valid_reg;
    assign ca_contacts   = m_ca_reg;
    assign cb_contacts   = m_cb_reg;
    assign result_status = m_status_reg;
    assign q_idx         = q_reg;

endmodule

// File: sv/residue_contact_counter.sv
`timescale 1ns / 1ps
// top level: residue contact counter with store, controller and distance pipeline
//
// Input beats carry one item each; s_tuser holds the mode (load, query, clear).
// A load appends the residue in s_tdata to the store, a clear empties it, and a
// query counts CA and CB contacts of the stored residue at query_index against
// every other stored residue. Every input beat gives exactly one result beat.
// Load, clear and unused modes: the result is registered in the output
// register on leaving ST_RESULT, and the next beat is taken once back in idle.
// Query: one read of the queried residue, then one pair per cycle over all N
// stored residues through a five-stage distance pipeline; the block drains
// the pipeline and takes no new beat until the result is registered.
// The sweep runs over the store's single read port.
// A query beyond the store or a load into a full store returns at once with a
// status code and zero counts.
// cfg_wr_en writes cutoff_distance_sq (index 0) or min_separation (index 1)
// from cfg_wdata; write only while no item is in flight.
// Reset (aresetn low, synchronous) empties the store and restores the cutoff
// of 8 A and a minimum separation of 4. A stalled result beat is held in the
// output register; s_tready stays high in idle, so one more item is taken and
// worked on, then the block waits until the output register is free.
module residue_contact_counter #(
    parameter int MAX_RESIDUES = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // ca_x, ca_y, ca_z, cb_x, cb_y, cb_z, residue_number, query_index, zero pad
    input  logic [rcc_pkg::S_TDATA_W-1:0]       s_tdata,
    // mode
    input  logic [rcc_pkg::MODE_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ca_contacts, cb_contacts, status, zero pad
    output logic [rcc_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcc_pkg::CUTOFF_W-1:0]        cfg_wdata
);
    import rcc_pkg::*;

    localparam int IDX_W     = $clog2(MAX_RESIDUES);
    localparam int RESNUM_LO = 6 * COORD_W;
    localparam int QIDX_LO   = RESNUM_LO + RESNUM_W;
    localparam int M_PAD_W   = M_TDATA_W - 2 * COUNT_W - STATUS_W;

    entry_t              wr_entry;
    dp_cmd_t             cmd;
    dp_status_t          dp_status;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    q_idx;
    logic [COUNT_W-1:0]  ca_contacts;
    logic [COUNT_W-1:0]  cb_contacts;
    logic [STATUS_W-1:0] result_status;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wr_entry.ca[k] = s_tdata[k * COORD_W +: COORD_W];
            wr_entry.cb[k] = s_tdata[(k + 3) * COORD_W +: COORD_W];
        end
        wr_entry.resnum = s_tdata[RESNUM_LO +: RESNUM_W];
    end

    assign m_tdata = {M_PAD_W'(0), result_status, cb_contacts, ca_contacts};

    rcc_ctrl #(
        .MAX_RESIDUES (MAX_RESIDUES),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .mode          (s_tuser),
        .query_index   (s_tdata[QIDX_LO +: QIDX_W]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .ca_contacts   (ca_contacts),
        .cb_contacts   (cb_contacts),
        .result_status (result_status),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .q_idx         (q_idx),
        .dp_status     (dp_status)
    );

    rcc_datapath #(
        .MAX_RESIDUES (MAX_RESIDUES),
        .IDX_W        (IDX_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .wr_entry  (wr_entry),
        .rd_addr   (rd_addr),
        .q_idx     (q_idx),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .status    (dp_status)
    );

endmodule
